/* design/bba_pkg.sv */
// shared constants and types for the buddy block allocator
package bba_pkg;
  localparam int unsigned OrderCapDefault = 10;
  localparam int unsigned ReqW = 23;
  localparam int unsigned OffW = 23;
  localparam int unsigned OrdW = 4;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned UnitW = 13;
  localparam int unsigned HdrW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_BLOCK = 2'd0,
    CFG_POOL_ORDER = 2'd1,
    CFG_HEADER = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    ST_OK = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO = 2'd2,
    ST_FREE_IGN = 2'd3
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  // round up to a multiple of eight
  function automatic logic [UnitW:0] round8(input logic [UnitW-1:0] x);
    logic [UnitW:0] s;
    s = {1'b0, x} + (UnitW+1)'(7);
    return s & ~(UnitW+1)'(7);
  endfunction
endpackage

/* design/bba_mul.sv */
// shift-add multiplier for the payload offset, one bit per cycle
module bba_mul #(
  parameter int unsigned AW = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [AW-1:0]          a_i,
  input  logic [bba_pkg::OffW-1:0] b_i,
  output logic                   busy_o,
  output logic [bba_pkg::OffW-1:0] p_o
);
  logic [AW-1:0] a_q;
  logic [bba_pkg::OffW-1:0] b_q, p_q;
  logic busy_q;

  // one multiplier bit a cycle, low bit first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && a_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q && a_q != '0) begin
      if (a_q[0]) p_q <= p_q + b_q;
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign busy_o = busy_q;
  assign p_o = p_q;
endmodule

/* design/buddy_block_allocator_top.sv */
// buddy block allocator top level: sequencer, free stacks and block memories
//
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      operation, request_bytes, block_index
// m_axis    out  tvalid/tready      status, granted_index, granted_order, payload_offset
// cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// an allocate steps order by order through the size search and the stack scan,
// splits down once per order and then runs the shift-add offset multiply over
// the index bits (up to ORDER_CAP); a free pushes its block and runs the
// multiply, and a rejected word skips the multiply. a finished result waits in the
// output register, and the next word runs up to its own result while that one is
// not taken. after reset or a write to a used config register, a clearing pass over
// all 2^ORDER_CAP blocks wipes the allocated marks and links before words are taken.
module buddy_block_allocator_top #(
  parameter int unsigned ORDER_CAP = bba_pkg::OrderCapDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[0], request_bytes[23:1], block_index[33:24], zeros
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], granted_index[11:2], granted_order[15:12], payload_offset[38:16], zeros
  output logic [((2+ORDER_CAP+4+23+7)/8)*8-1:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bba_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned NBlk = 1 << ORDER_CAP;
  localparam int unsigned NOrd = ORDER_CAP + 1;
  localparam int unsigned IW = ORDER_CAP;
  localparam int unsigned OW = $clog2(NOrd + 1);
  localparam int unsigned OutW = 2 + IW + 4 + 23;
  localparam int unsigned OutPW = ((OutW + 7) / 8) * 8;
  localparam int unsigned TopRst = (ORDER_CAP < 10) ? ORDER_CAP : 10;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEED, S_SCAN, S_RD, S_POP, S_SPLIT, S_PUSHF,
    S_MUL, S_MULW, S_OUT
  } state_e;

  // configuration registers
  logic [12:0] minb_q;
  logic [3:0]  pord_q;
  logic [6:0]  hdr_q;
  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == bba_pkg::CFG_MIN_BLOCK
                   || cfg_idx_i == bba_pkg::CFG_POOL_ORDER
                   || cfg_idx_i == bba_pkg::CFG_HEADER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minb_q <= 13'd32;
      pord_q <= 4'd10;
      hdr_q  <= 7'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bba_pkg::CFG_MIN_BLOCK:  minb_q <= cfg_data_i;
        bba_pkg::CFG_POOL_ORDER: pord_q <= cfg_data_i[3:0];
        bba_pkg::CFG_HEADER:     hdr_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // derived unit size and top order, and the top order after a config write
  logic [13:0] m8, h8, unit;
  logic [OW-1:0] top, top_nxt;
  logic [3:0] pord_nxt;
  always_comb begin
    m8 = bba_pkg::round8(minb_q);
    h8 = bba_pkg::round8({6'd0, hdr_q});
    unit = (m8 < h8) ? h8 : m8;
    if (unit == '0) unit = 14'd8;
    top = (pord_q > 4'(ORDER_CAP)) ? OW'(ORDER_CAP) : OW'(pord_q);
    pord_nxt = (cfg_idx_i == bba_pkg::CFG_POOL_ORDER) ? cfg_data_i[3:0] : pord_q;
    top_nxt = (pord_nxt > 4'(ORDER_CAP)) ? OW'(ORDER_CAP) : OW'(pord_nxt);
  end

  // free stack heads
  logic [IW-1:0] head_q [NOrd];
  logic [NOrd-1:0] hval_q;

  // memories
  logic [IW:0]   link_mem [NBlk];
  logic [3:0]    ord_mem [NBlk];
  logic          mark_mem [NBlk];
  logic [IW:0]   link_rd;
  logic [3:0]    ord_rd;
  logic          mark_rd;

  state_e state_q;
  logic [IW-1:0] clr_q, blk_q;
  logic op_q;
  logic [22:0] req_q;
  logic [IW-1:0] bidx_q;
  logic [OW-1:0] need_q, ord_q;
  logic [24:0] total_q, usz_q;
  logic [1:0] st_q;
  logic [IW-1:0] gi_q;
  logic [3:0] go_q;
  logic [22:0] off_q;
  logic ovalid_q;
  logic [OutPW-1:0] word, oword_q;
  logic out_load;

  // memory port controls
  logic lk_we, om_we, mk_we;
  logic [IW-1:0] lk_wa, om_wa, mk_wa, rd_a;
  logic [IW:0] lk_wd;
  logic mk_wd;

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (om_we) ord_mem[om_wa] <= ord_q[3:0];
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    link_rd <= link_mem[rd_a];
    ord_rd <= ord_mem[rd_a];
    mark_rd <= mark_mem[rd_a];
  end

  // offset multiplier
  logic mul_start, mul_busy;
  logic [22:0] mul_p;
  bba_mul #(.AW(IW)) u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(mul_start),
    .a_i(gi_q), .b_i(usz_q[22:0]), .busy_o(mul_busy), .p_o(mul_p)
  );

  // memory port decode
  always_comb begin
    lk_we = 1'b0; om_we = 1'b0; mk_we = 1'b0;
    lk_wa = blk_q; om_wa = blk_q; mk_wa = blk_q;
    lk_wd = '0; mk_wd = 1'b0;
    rd_a = (state_q == S_IDLE) ? s_axis_tdata[24 +: IW] : blk_q;
    mul_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mk_we = 1'b1; mk_wa = clr_q;
        lk_we = 1'b1; lk_wa = clr_q;
      end
      S_SPLIT: begin
        if (ord_q > need_q) begin
          lk_we = 1'b1;
          lk_wa = blk_q + (IW'(1) << (ord_q - OW'(1)));
          lk_wd = {hval_q[ord_q - OW'(1)], head_q[ord_q - OW'(1)]};
        end else begin
          om_we = 1'b1; mk_we = 1'b1; mk_wd = 1'b1;
        end
      end
      S_PUSHF: begin
        lk_we = 1'b1; mk_we = 1'b1; mk_wd = 1'b0;
        lk_wd = {hval_q[ord_q], head_q[ord_q]};
      end
      S_MUL: mul_start = 1'b1;
      default: ;
    endcase
  end

  // result word, fields zeroed unless ok
  always_comb begin
    word = '0;
    word[1:0] = st_q;
    if (st_q == bba_pkg::ST_OK) begin
      word[2 +: IW] = gi_q;
      word[2+IW +: 4] = go_q;
      word[6+IW +: 23] = off_q;
    end
  end

  // result moves to the output register once that one is free
  assign out_load = (state_q == S_OUT) && (!ovalid_q || m_axis_tready) && !cfg_hit;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      hval_q <= NOrd'(1) << TopRst;
      ovalid_q <= 1'b0;
      oword_q <= '0;
      for (int i = 0; i < NOrd; i++) head_q[i] <= '0;
    end else begin
      // output word held until taken
      ovalid_q <= out_load || (ovalid_q && !m_axis_tready);
      if (out_load) oword_q <= word;
      if (cfg_hit) begin
        state_q <= S_CLEAR;
        clr_q <= '0;
        hval_q <= NOrd'(1) << top_nxt;
        for (int i = 0; i < NOrd; i++) head_q[i] <= '0;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + IW'(1);
            if (clr_q == IW'(NBlk - 1)) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              op_q <= s_axis_tdata[0];
              req_q <= s_axis_tdata[23:1];
              bidx_q <= s_axis_tdata[24 +: IW];
              blk_q <= s_axis_tdata[24 +: IW];
              need_q <= '0;
              usz_q <= 25'(unit);
              total_q <= (25'(s_axis_tdata[23:1]) + 25'(hdr_q) + 25'd7) & ~25'd7;
              state_q <= S_NEED;
            end
          end
          S_NEED: begin
            if (op_q == bba_pkg::OP_FREE) begin
              if ((bidx_q >> top) != '0 || !mark_rd) begin
                st_q <= bba_pkg::ST_FREE_IGN;
                state_q <= S_OUT;
              end else begin
                ord_q <= (OW'(ord_rd) > top) ? top : OW'(ord_rd);
                state_q <= S_PUSHF;
              end
            end else if (req_q == '0) begin
              st_q <= bba_pkg::ST_ZERO;
              state_q <= S_OUT;
            end else if (usz_q < total_q && need_q < top) begin
              usz_q <= usz_q << 1;
              need_q <= need_q + OW'(1);
            end else if (usz_q < total_q) begin
              st_q <= bba_pkg::ST_NO_SPACE;
              state_q <= S_OUT;
            end else begin
              ord_q <= need_q;
              state_q <= S_SCAN;
            end
          end
          S_SCAN: begin
            if (ord_q > top) begin
              st_q <= bba_pkg::ST_NO_SPACE;
              state_q <= S_OUT;
            end else if (hval_q[ord_q]) begin
              blk_q <= head_q[ord_q];
              state_q <= S_RD;
            end else begin
              ord_q <= ord_q + OW'(1);
            end
          end
          // link of the popped block is being read
          S_RD: state_q <= S_POP;
          S_POP: begin
            head_q[ord_q] <= link_rd[IW-1:0];
            hval_q[ord_q] <= link_rd[IW];
            state_q <= S_SPLIT;
          end
          S_SPLIT: begin
            if (ord_q > need_q) begin
              head_q[ord_q - OW'(1)] <= blk_q + (IW'(1) << (ord_q - OW'(1)));
              hval_q[ord_q - OW'(1)] <= 1'b1;
              ord_q <= ord_q - OW'(1);
            end else begin
              st_q <= bba_pkg::ST_OK;
              gi_q <= blk_q;
              go_q <= 4'(need_q);
              state_q <= S_MUL;
            end
          end
          S_PUSHF: begin
            head_q[ord_q] <= blk_q;
            hval_q[ord_q] <= 1'b1;
            st_q <= bba_pkg::ST_OK;
            gi_q <= blk_q;
            go_q <= 4'(ord_q);
            usz_q <= 25'(unit) << ord_q;
            state_q <= S_MUL;
          end
          S_MUL: state_q <= S_MULW;
          S_MULW: begin
            if (!mul_busy) begin
              off_q <= mul_p + 23'(hdr_q);
              state_q <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_load) state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_hit;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = oword_q;
endmodule

/* test/tb_buddy_block_allocator_top.sv */
// testbench for the buddy block allocator: directed table, random traffic, result checking
`timescale 1ns / 100ps

module tb_buddy_block_allocator_top;

  localparam int unsigned MaxOrd = 10;
  localparam int unsigned NumBlk = 1 << MaxOrd;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    bba_pkg::status_e st;
    logic [9:0]  gi;
    logic [3:0]  go;
    logic [22:0] off;
  } grant_t;

  typedef struct {
    logic        op;
    logic [22:0] req;
    logic [9:0]  idx;
    bit          known;
    grant_t      res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // operation, request_bytes, block_index, zeros
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status, granted_index, granted_order, payload_offset, zeros
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [bba_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [bba_pkg::CfgDataW-1:0] cfg_data_i = '0;

  buddy_block_allocator_top #(.ORDER_CAP(MaxOrd)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // allocator mirror: configuration and free stacks
  logic [12:0] min_bytes;
  logic [3:0]  pool_ord;
  logic [6:0]  hdr_bytes;
  logic [9:0]  stack_head [MaxOrd+1];
  bit          head_ok [MaxOrd+1];
  logic [9:0]  link_next [NumBlk];
  bit          link_ok [NumBlk];
  logic [3:0]  blk_order [NumBlk];
  bit          in_use [NumBlk];

  grant_t      grant_q [$];
  int unsigned live_q [$];
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned cycles = 0;

  function automatic longint unsigned unit_size();
    longint unsigned m, h;
    m = (longint'(min_bytes) + 7) & ~64'd7;
    h = (longint'(hdr_bytes) + 7) & ~64'd7;
    if (m < h) m = h;
    if (m == 0) m = 8;
    return m;
  endfunction

  function automatic int unsigned top_ord();
    return (pool_ord > MaxOrd) ? MaxOrd : pool_ord;
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i <= MaxOrd; i++) head_ok[i] = 0;
    for (int i = 0; i < NumBlk; i++) begin
      in_use[i] = 0;
      link_ok[i] = 0;
    end
    stack_head[top_ord()] = '0;
    head_ok[top_ord()] = 1;
    live_q.delete();
  endfunction

  function automatic void push_free(int unsigned ord, int unsigned blk);
    link_next[blk] = stack_head[ord];
    link_ok[blk] = head_ok[ord];
    stack_head[ord] = blk[9:0];
    head_ok[ord] = 1;
  endfunction

  // allocate or free against the mirror, return the grant
  function automatic grant_t serve_request(logic op, logic [22:0] req, logic [9:0] idx);
    grant_t r;
    int unsigned n, need, ord, blk;
    longint unsigned unit, total, off;
    r = '{st: bba_pkg::ST_OK, gi: '0, go: '0, off: '0};
    n = top_ord();
    unit = unit_size();
    if (op == bba_pkg::OP_ALLOC) begin
      if (req == 0) begin
        r.st = bba_pkg::ST_ZERO;
        return r;
      end
      total = (longint'(req) + hdr_bytes + 7) & ~64'd7;
      need = 0;
      while ((unit << need) < total && need < n) need++;
      if ((unit << need) < total) begin
        r.st = bba_pkg::ST_NO_SPACE;
        return r;
      end
      ord = need;
      while (ord <= n && !head_ok[ord]) ord++;
      if (ord > n) begin
        r.st = bba_pkg::ST_NO_SPACE;
        return r;
      end
      blk = stack_head[ord];
      stack_head[ord] = link_next[blk];
      head_ok[ord] = link_ok[blk];
      while (ord > need) begin
        ord--;
        push_free(ord, (blk + (1 << ord)) % NumBlk);
      end
      blk_order[blk] = need[3:0];
      in_use[blk] = 1;
      live_q.push_back(blk);
    end else begin
      blk = idx;
      if (blk >= (1 << n) || !in_use[blk]) begin
        r.st = bba_pkg::ST_FREE_IGN;
        return r;
      end
      in_use[blk] = 0;
      need = blk_order[blk];
      if (need > n) need = n;
      push_free(need, blk);
      foreach (live_q[i]) if (live_q[i] == blk) begin
        live_q.delete(i);
        break;
      end
    end
    off = longint'(blk) * (unit << need) + hdr_bytes;
    r.gi = blk[9:0];
    r.go = need[3:0];
    r.off = off[22:0];
    return r;
  endfunction

  function automatic bit quiet_window();
    return (cycles / 3000) % 4 == 1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (quiet_window() || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one word, wait for acceptance, queue the expected grant
  task automatic send_word(logic op, logic [22:0] req, logic [9:0] idx,
                           bit known = 0, grant_t typed = '0);
    grant_t g;
    repeat (pick_gap()) @(negedge clk_i);
    s_axis_tdata = {6'd0, idx, req, op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    g = serve_request(op, req, idx);
    grant_q.push_back(known ? typed : g);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // write one register once the pipeline has drained
  task automatic write_reg(bba_pkg::cfg_idx_e ri, logic [12:0] val);
    wait (grant_q.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = ri;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (ri)
      bba_pkg::CFG_MIN_BLOCK:  min_bytes = val;
      bba_pkg::CFG_POOL_ORDER: pool_ord = val[3:0];
      bba_pkg::CFG_HEADER:     hdr_bytes = val[6:0];
      default:                 return;
    endcase
    reset_pool();
  endtask

  // random traffic: mostly allocs of fitting sizes and frees of live blocks
  task automatic random_items(int unsigned count);
    int unsigned p, sh;
    longint unsigned lim;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2 && $urandom_range(0, 1)) wait (grant_q.size() == 0);
      p = $urandom_range(0, 99);
      if (p < 50) begin
        sh = $urandom_range(0, top_ord());
        lim = (unit_size() << sh);
        if (lim > 23'h7FFFFF) lim = 23'h7FFFFF;
        send_word(bba_pkg::OP_ALLOC, 23'($urandom_range(1, int'(lim))),
                  10'($urandom_range(0, 1023)));
      end else if (p < 85 && live_q.size() > 0) begin
        send_word(bba_pkg::OP_FREE, 23'($urandom()),
                  10'(live_q[$urandom_range(0, live_q.size() - 1)]));
      end else if (p < 92) begin
        send_word(bba_pkg::OP_FREE, 23'($urandom()), 10'($urandom_range(0, 1023)));
      end else if (p < 97) begin
        send_word(bba_pkg::OP_ALLOC, 23'($urandom_range(0, 23'h7FFFFF)), 10'($urandom()));
      end else begin
        send_word(bba_pkg::OP_ALLOC, 23'd0, 10'($urandom()));
      end
    end
  endtask

  function automatic void report(string what, longint unsigned exp_v, longint unsigned act_v);
    if (mismatches < 10)
      $display("mismatch on word %0d %s: expected %0h, got %0h", words_seen, what, exp_v, act_v);
    mismatches++;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    grant_t e, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a = '{st: bba_pkg::status_e'(m_axis_tdata[1:0]), gi: m_axis_tdata[11:2],
            go: m_axis_tdata[15:12], off: m_axis_tdata[38:16]};
      if (grant_q.size() == 0) begin
        report("unexpected word", 0, a);
      end else begin
        e = grant_q.pop_front();
        if (a.st != e.st) report("status", e.st, a.st);
        if (a.gi != e.gi) report("granted_index", e.gi, a.gi);
        if (a.go != e.go) report("granted_order", e.go, a.go);
        if (a.off != e.off) report("payload_offset", e.off, a.off);
      end
      words_seen++;
    end
  end

  // receiver stalls, with one long hold-off
  initial begin
    bit held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (!held && words_seen >= 150) begin
        held = 1;
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t tab [14];
    tab = '{
      '{bba_pkg::OP_ALLOC, 23'd0,       10'd5,   1, '{bba_pkg::ST_ZERO, 10'd0, 4'd0, 23'd0}},
      '{bba_pkg::OP_ALLOC, 23'h7FFFFF,  10'd0,   1,
        '{bba_pkg::ST_NO_SPACE, 10'd0, 4'd0, 23'd0}},
      '{bba_pkg::OP_ALLOC, 23'd4194304, 10'h3FF, 1,
        '{bba_pkg::ST_NO_SPACE, 10'd0, 4'd0, 23'd0}},
      '{bba_pkg::OP_FREE,  23'h7FFFFF,  10'h3FF, 1,
        '{bba_pkg::ST_FREE_IGN, 10'd0, 4'd0, 23'd0}},
      '{bba_pkg::OP_ALLOC, 23'd16,      10'd0,   1, '{bba_pkg::ST_OK, 10'd0, 4'd0, 23'd16}},
      '{bba_pkg::OP_FREE,  23'd0,       10'd0,   1, '{bba_pkg::ST_OK, 10'd0, 4'd0, 23'd16}},
      '{bba_pkg::OP_FREE,  23'd0,       10'd0,   1,
        '{bba_pkg::ST_FREE_IGN, 10'd0, 4'd0, 23'd0}},
      '{bba_pkg::OP_ALLOC, 23'd1,       10'd0,   0, '0},
      '{bba_pkg::OP_ALLOC, 23'd17,      10'd0,   0, '0},
      '{bba_pkg::OP_ALLOC, 23'd500,     10'd0,   0, '0},
      '{bba_pkg::OP_ALLOC, 23'd32752,   10'd0,   0, '0},
      '{bba_pkg::OP_ALLOC, 23'd16368,   10'd0,   0, '0},
      '{bba_pkg::OP_FREE,  23'd0,       10'd1,   0, '0},
      '{bba_pkg::OP_ALLOC, 23'd8,       10'd0,   0, '0}
    };
    min_bytes = 13'd32;
    pool_ord = 4'd10;
    hdr_bytes = 7'd16;
    reset_pool();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (tab[i]) send_word(tab[i].op, tab[i].req, tab[i].idx, tab[i].known, tab[i].res);
    random_items(90);

    // smallest pool and sizes
    write_reg(bba_pkg::CFG_MIN_BLOCK, 13'd8);
    write_reg(bba_pkg::CFG_POOL_ORDER, 13'd0);
    write_reg(bba_pkg::CFG_HEADER, 13'd8);
    random_items(40);
    // large blocks and headers, full pool order
    write_reg(bba_pkg::CFG_MIN_BLOCK, 13'd4096);
    write_reg(bba_pkg::CFG_POOL_ORDER, 13'd10);
    write_reg(bba_pkg::CFG_HEADER, 13'd64);
    random_items(90);
    // zero sizes and an over-range pool order
    write_reg(bba_pkg::CFG_MIN_BLOCK, 13'd0);
    write_reg(bba_pkg::CFG_HEADER, 13'd0);
    write_reg(bba_pkg::CFG_POOL_ORDER, 13'h1FFF);
    random_items(90);
    // odd sizes, header below the block size
    write_reg(bba_pkg::CFG_MIN_BLOCK, 13'd8191);
    write_reg(bba_pkg::CFG_HEADER, 13'd127);
    write_reg(bba_pkg::CFG_POOL_ORDER, 13'd4);
    random_items(70);
    // mid sizes, then an unused index that leaves the pool alone
    write_reg(bba_pkg::CFG_MIN_BLOCK, 13'd20);
    write_reg(bba_pkg::CFG_HEADER, 13'd40);
    write_reg(bba_pkg::CFG_POOL_ORDER, 13'd6);
    random_items(40);
    write_reg(bba_pkg::CFG_NONE, 13'h1FFF);
    random_items(90);

    wait (grant_q.size() == 0);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
